// ===== rtl/core/bounded_lifo_stack_defines.svh =====
// Assertion macros shared by the stack RTL.
`ifndef BOUNDED_LIFO_STACK_DEFINES_SVH
`define BOUNDED_LIFO_STACK_DEFINES_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define BLSTK_ASSERT_NOW(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("stack assertion failed");
// Check that an antecedent is followed by a consequent in the next cycle.
`define BLSTK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack assertion failed");
`else
`define BLSTK_ASSERT_NOW(label, clk, rst_n, cond)
`define BLSTK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/blstk_pkg.sv =====
// Types and constants shared by the stack controller, datapath and top level.
package blstk_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FILL_OUT_W = 6;
  localparam int unsigned EXT_W      = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_TOP     = 3'd2,
    KIND_POP_TOP = 3'd3,
    KIND_CLEAR   = 3'd4,
    KIND_PURGE   = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_SUCCESS   = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // transaction taken on the input channel this cycle
    logic top_load;  // capture the word read from the store into the result
    logic scan;      // run one step of the purge compaction
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic scan_done;
  } sts_t;

endpackage

// ===== rtl/core/blstk_datapath.sv =====
// Stack datapath: entry store, fill counter, compaction scan and result register.
`include "bounded_lifo_stack_defines.svh"

module blstk_datapath #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  blstk_pkg::cmd_t                  cmd_i,
  input  logic [blstk_pkg::KIND_W-1:0]     kind_i,
  input  logic [blstk_pkg::WORD_W-1:0]     value_i,
  output blstk_pkg::sts_t                  sts_o,
  output logic [blstk_pkg::STATUS_W-1:0]   status_o,
  output logic [blstk_pkg::WORD_W-1:0]     top_word_o,
  output logic [blstk_pkg::FILL_OUT_W-1:0] fill_count_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [FILL_W-1:0]     rd_q, rd_d;
  logic [FILL_W-1:0]     wr_q, wr_d;
  logic                  pend_q, pend_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  blstk_pkg::status_e    status_q, status_d;
  logic [blstk_pkg::WORD_W-1:0] word_q, word_d;

  logic [blstk_pkg::EXT_W-1:0] val_ext, rd_ext;
  logic [DATA_WIDTH-1:0] val_w;
  logic [FILL_W-1:0]     top_idx;
  logic                  empty, full, scan_end, keep;
  logic                  rd_en, wr_en;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  blstk_pkg::kind_e      kind;

  assign kind     = blstk_pkg::kind_e'(kind_i);
  assign val_ext  = blstk_pkg::EXT_W'(value_i);
  assign val_w    = val_ext[DATA_WIDTH-1:0];
  assign rd_ext   = blstk_pkg::EXT_W'(rdata_q);
  assign empty    = (fill_q == '0);
  assign full     = (fill_q == FILL_W'(DEPTH));
  assign top_idx  = fill_q - FILL_W'(1);
  assign scan_end = (rd_q == fill_q);
  assign keep     = pend_q && (rdata_q != val_q);

  // Read port: the top entry at accept, the scan pointer while compacting.
  assign rd_en   = cmd_i.accept || (cmd_i.scan && !scan_end);
  assign rd_addr = cmd_i.scan ? rd_q[ADDR_W-1:0] : top_idx[ADDR_W-1:0];

  // Write port: a push at accept, a kept entry moving down while compacting.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_q[ADDR_W-1:0];
    wr_data = val_w;
    if (cmd_i.accept && kind == blstk_pkg::KIND_PUSH && !full) begin
      wr_en = 1'b1;
    end else if (cmd_i.scan && keep) begin
      wr_en   = 1'b1;
      wr_addr = wr_q[ADDR_W-1:0];
      wr_data = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    fill_d   = fill_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    pend_d   = pend_q;
    val_d    = val_q;
    status_d = status_q;
    word_d   = word_q;
    if (cmd_i.accept) begin
      status_d = blstk_pkg::ST_SUCCESS;
      word_d   = '0;
      case (kind)
        blstk_pkg::KIND_PUSH: begin
          if (full) begin
            status_d = blstk_pkg::ST_OVERFLOW;
          end else begin
            fill_d = fill_q + FILL_W'(1);
          end
        end
        blstk_pkg::KIND_POP, blstk_pkg::KIND_POP_TOP: begin
          if (empty) begin
            status_d = blstk_pkg::ST_UNDERFLOW;
          end else begin
            fill_d = top_idx;
          end
        end
        blstk_pkg::KIND_TOP: begin
          if (empty) begin
            status_d = blstk_pkg::ST_UNDERFLOW;
          end
        end
        blstk_pkg::KIND_CLEAR: begin
          fill_d = '0;
        end
        blstk_pkg::KIND_PURGE: begin
          val_d  = val_w;
          rd_d   = '0;
          wr_d   = '0;
          pend_d = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.top_load) begin
      word_d = rd_ext[blstk_pkg::WORD_W-1:0];
    end else if (cmd_i.scan) begin
      // Advance the read pointer and count the entries that survive.
      pend_d = !scan_end;
      if (!scan_end) begin
        rd_d = rd_q + FILL_W'(1);
      end
      if (keep) begin
        wr_d = wr_q + FILL_W'(1);
      end
      if (scan_end && !pend_q) begin
        fill_d = wr_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rd_q   <= '0;
      wr_q   <= '0;
      pend_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    status_q <= status_d;
    word_q   <= word_d;
  end

  assign sts_o.empty     = empty;
  assign sts_o.scan_done = scan_end && !pend_q;

  assign status_o     = status_q;
  assign top_word_o   = word_q;
  assign fill_count_o = blstk_pkg::FILL_OUT_W'(fill_q);
  assign is_empty_o   = empty;
  assign is_full_o    = full;

  `BLSTK_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, fill_q <= FILL_W'(DEPTH))
  `BLSTK_ASSERT_NOW(a_wr_behind_rd, clk_i, rst_ni, !cmd_i.scan || (wr_q <= rd_q))
  `BLSTK_ASSERT_NEXT(a_push_grows, clk_i, rst_ni,
                     cmd_i.accept && kind == blstk_pkg::KIND_PUSH && !full,
                     fill_q == $past(fill_q) + FILL_W'(1))

endmodule

// ===== rtl/core/blstk_ctrl.sv =====
// Stack controller: handshakes and sequencing of reads and compaction.
`include "bounded_lifo_stack_defines.svh"

module blstk_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [blstk_pkg::KIND_W-1:0] kind_i,
  input  logic                         out_stall_i,
  input  blstk_pkg::sts_t              sts_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  output blstk_pkg::cmd_t              cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_DEL,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  blstk_pkg::kind_e kind;
  logic             ready, accept;

  assign kind = blstk_pkg::kind_e'(kind_i);

  // Take a new transaction when idle, or as the held result leaves.
  assign ready  = (state_q == S_IDLE) || (state_q == S_OUT && !out_stall_i);
  assign accept = in_valid_i && ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE, S_OUT: begin
        if (accept) begin
          if ((kind == blstk_pkg::KIND_TOP || kind == blstk_pkg::KIND_POP_TOP) &&
              !sts_i.empty) begin
            state_d = S_TOP;
          end else if (kind == blstk_pkg::KIND_PURGE) begin
            state_d = S_DEL;
          end else begin
            state_d = S_OUT;
          end
        end else if (state_q == S_OUT && !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      S_TOP: begin
        state_d = S_OUT;
      end
      S_DEL: begin
        if (sts_i.scan_done) begin
          state_d = S_OUT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o      = !ready;
  assign out_valid_o     = (state_q == S_OUT);
  assign cmd_o.accept    = accept;
  assign cmd_o.top_load  = (state_q == S_TOP);
  assign cmd_o.scan      = (state_q == S_DEL);

  `BLSTK_ASSERT_NEXT(a_top_one_cycle, clk_i, rst_ni, state_q == S_TOP, state_q == S_OUT)
  `BLSTK_ASSERT_NEXT(a_scan_exit, clk_i, rst_ni,
                     state_q == S_DEL && sts_i.scan_done, state_q == S_OUT)
  `BLSTK_ASSERT_NEXT(a_peek_reads, clk_i, rst_ni,
                     accept && !sts_i.empty &&
                     (kind == blstk_pkg::KIND_TOP || kind == blstk_pkg::KIND_POP_TOP),
                     state_q == S_TOP)

endmodule

// ===== rtl/core/bounded_lifo_stack.sv =====
// Top level of the bounded LIFO stack.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries kind_i and value_i; a
//   transaction is taken at a clock edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i) carries one result per input
//   transaction: status_o, top_word_o, fill_count_o, is_empty_o, is_full_o.
//   Results: push, pop, clear and failed reads show their result the cycle
//   after acceptance; top and pop_top go through the registered read port of
//   the entry store, then a state that loads the result; purge scans the
//   stored entries, one store entry read per cycle while kept entries move
//   down, and then sets the fill count to the number kept.
//   Throughput: one transaction per cycle for push, pop and clear while
//   out_stall_i is low, since a new transaction is taken in the same cycle
//   the held result leaves; top, pop_top and purge stall the input until done.
//   Stall: while out_stall_i holds a result, the result and the fill count
//   stay put and no new transaction is taken.
//   Reset: the fill count clears to zero and the block goes idle at once;
//   the entry store is not cleared, since only written entries are read.
module bounded_lifo_stack #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [blstk_pkg::KIND_W-1:0]     kind_i,
  input  logic [blstk_pkg::WORD_W-1:0]     value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [blstk_pkg::STATUS_W-1:0]   status_o,
  output logic [blstk_pkg::WORD_W-1:0]     top_word_o,
  output logic [blstk_pkg::FILL_OUT_W-1:0] fill_count_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);

  // Commands go from controller to datapath, status comes back.
  blstk_pkg::cmd_t cmd;
  blstk_pkg::sts_t sts;

  blstk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  blstk_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .sts_o        (sts),
    .status_o     (status_o),
    .top_word_o   (top_word_o),
    .fill_count_o (fill_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

endmodule
